/* rtl/nnt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_pkg - shared types and constants for the nearest-neighbour tour core
//
// Fixed field widths, controller state encoding, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nnt_pkg;

    // Fixed port field widths
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int DIST_IN_W  = 24;
    localparam int CITY_OUT_W = 5;
    localparam int TOTAL_W    = 29;
    localparam int COUNT_W    = 6;

    // Saturation limit of the reported tour length
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_CLOSE_RD,
        ST_CLOSE_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // write accepted entry into the matrix
        logic tour_init;   // clear visited flags, sum, current city
        logic emit_start;  // present opening city 0
        logic scan_clear;  // restart the row scan
        logic scan_issue;  // read one candidate of the current row
        logic commit;      // move to best candidate and present it
        logic close_issue; // read distance back to city 0
        logic close_emit;  // add return leg, present closing item
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take an item this cycle
        logic scan_last;   // candidate being read is the last of the row
        logic no_steps;    // no tour steps remain
        logic final_step;  // exactly one tour step remains
    } status_t;

endpackage

/* rtl/nnt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_ctrl - tour sequencer
//
// Takes matrix entries while idle, then walks the tour: opening city, one
// row scan per step, and the closing leg back to city 0.
// ----------------------------------------------------------------------------
module nnt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last_entry,
    output logic             s_ready,
    input  nnt_pkg::status_t status,
    output nnt_pkg::cmd_t    cmd
);

    nnt_pkg::state_t state_reg;
    nnt_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nnt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            nnt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_entry) begin
                        cmd.tour_init = 1'b1;
                        state_next    = nnt_pkg::ST_START;
                    end
                end
            end
            nnt_pkg::ST_START: begin
                if (status.out_free) begin
                    cmd.emit_start = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = status.no_steps ? nnt_pkg::ST_CLOSE_RD
                                                     : nnt_pkg::ST_SCAN;
                end
            end
            nnt_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = nnt_pkg::ST_DRAIN;
                end
            end
            nnt_pkg::ST_DRAIN: begin
                // last candidate is compared in this cycle
                state_next = nnt_pkg::ST_COMMIT;
            end
            nnt_pkg::ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit     = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = status.final_step ? nnt_pkg::ST_CLOSE_RD
                                                       : nnt_pkg::ST_SCAN;
                end
            end
            nnt_pkg::ST_CLOSE_RD: begin
                cmd.close_issue = 1'b1;
                state_next      = nnt_pkg::ST_CLOSE_EMIT;
            end
            nnt_pkg::ST_CLOSE_EMIT: begin
                if (status.out_free) begin
                    cmd.close_emit = 1'b1;
                    state_next     = nnt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nnt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/nnt_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_dpath - distance memory, scan compare and tour accumulators
//
// Holds the matrix in a one-write one-read memory with registered read,
// tracks visited cities, keeps the running best candidate of a row scan and
// the tour length, and owns the result register.
// ----------------------------------------------------------------------------
module nnt_dpath #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    input  logic [nnt_pkg::COUNT_W-1:0]     cfg_data,
    // input item
    input  logic [nnt_pkg::ROW_W-1:0]       s_row_index,
    input  logic [nnt_pkg::COL_W-1:0]       s_col_index,
    input  logic [nnt_pkg::DIST_IN_W-1:0]   s_distance,
    // result item
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nnt_pkg::CITY_OUT_W-1:0]  m_city,
    output logic [nnt_pkg::TOTAL_W-1:0]     m_total_length,
    output logic                            m_last_of_run,
    // control
    input  nnt_pkg::cmd_t                   cmd,
    output nnt_pkg::status_t                status
);

    localparam int CW        = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int NW        = $clog2(MAX_CITIES + 1);
    localparam int MEM_DEPTH = 2 ** (2 * CW);
    localparam int SUM_W     = (DIST_WIDTH + NW > nnt_pkg::TOTAL_W + 1)
                               ? DIST_WIDTH + NW : nnt_pkg::TOTAL_W + 1;

    // Configuration register
    logic [nnt_pkg::COUNT_W-1:0] city_count_reg;

    // Tour state
    logic [NW-1:0]         n_reg;
    logic [NW-1:0]         rem_reg;
    logic [CW-1:0]         cur_reg;
    logic [CW-1:0]         j_reg;
    logic [MAX_CITIES-1:0] visited_reg;
    logic [SUM_W-1:0]      sum_reg;

    // Scan pipeline
    logic                  cand_valid_reg;
    logic [CW-1:0]         cand_j_reg;
    logic [DIST_WIDTH-1:0] rd_data_reg;
    logic                  found_reg;
    logic [CW-1:0]         best_reg;
    logic [DIST_WIDTH-1:0] best_d_reg;

    // Result register
    logic                            m_valid_reg;
    logic [nnt_pkg::CITY_OUT_W-1:0]  m_city_reg;
    logic [nnt_pkg::TOTAL_W-1:0]     m_total_reg;
    logic                            m_last_reg;

    // Distance memory
    logic [DIST_WIDTH-1:0] dist_mem [MEM_DEPTH];

    logic                  wr_en;
    logic [2*CW-1:0]       wr_addr;
    logic [2*CW-1:0]       rd_addr;
    logic [NW-1:0]         n_eff;
    logic                  take_cand;
    logic [SUM_W-1:0]      close_sum;
    logic [nnt_pkg::TOTAL_W-1:0] close_total;
    logic                  out_free;

    // Entries outside the store are dropped
    always_comb begin
        wr_en   = cmd.load
                  && (32'(s_row_index) < MAX_CITIES)
                  && (32'(s_col_index) < MAX_CITIES);
        wr_addr = {CW'(s_row_index), CW'(s_col_index)};
        rd_addr = cmd.close_issue ? {cur_reg, CW'(0)} : {cur_reg, j_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dist_mem[wr_addr] <= DIST_WIDTH'(s_distance);
        end
        if (cmd.scan_issue || cmd.close_issue) begin
            rd_data_reg <= dist_mem[rd_addr];
        end
    end

    // Configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg <= nnt_pkg::COUNT_W'(1);
        end else if (cfg_valid) begin
            city_count_reg <= cfg_data;
        end
    end

    // City count clamped to 1..MAX_CITIES
    always_comb begin
        if (city_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(city_count_reg) > MAX_CITIES) begin
            n_eff = NW'(MAX_CITIES);
        end else begin
            n_eff = NW'(city_count_reg);
        end
    end

    // Candidate beats running best (strictly smaller; lower index wins ties)
    assign take_cand = cand_valid_reg && (!found_reg || (rd_data_reg < best_d_reg));

    // Closing leg with saturation
    always_comb begin
        close_sum = sum_reg + SUM_W'(rd_data_reg);
        if (close_sum > SUM_W'(nnt_pkg::TOTAL_MAX)) begin
            close_total = nnt_pkg::TOTAL_MAX;
        end else begin
            close_total = nnt_pkg::TOTAL_W'(close_sum);
        end
    end

    // Tour state and scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg          <= NW'(1);
            rem_reg        <= '0;
            cur_reg        <= '0;
            j_reg          <= '0;
            visited_reg    <= '0;
            sum_reg        <= '0;
            cand_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            cand_valid_reg <= cmd.scan_issue && !visited_reg[j_reg];
            if (cmd.tour_init) begin
                n_reg       <= n_eff;
                rem_reg     <= n_eff - NW'(1);
                cur_reg     <= '0;
                visited_reg <= MAX_CITIES'(1);
                sum_reg     <= '0;
            end
            if (cmd.scan_clear) begin
                j_reg     <= '0;
                found_reg <= 1'b0;
            end else if (cmd.scan_issue) begin
                j_reg <= j_reg + CW'(1);
            end
            if (take_cand) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                sum_reg               <= sum_reg + SUM_W'(best_d_reg);
                visited_reg[best_reg] <= 1'b1;
                cur_reg               <= best_reg;
                rem_reg               <= rem_reg - NW'(1);
            end
            if (cmd.close_emit) begin
                sum_reg <= close_sum;
                cur_reg <= '0;
            end
        end
    end

    // Best candidate payload
    always_ff @(posedge aclk) begin
        cand_j_reg <= j_reg;
        if (take_cand) begin
            best_reg   <= cand_j_reg;
            best_d_reg <= rd_data_reg;
        end
    end

    // Result register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_start || cmd.commit || cmd.close_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            m_city_reg  <= '0;
            m_total_reg <= '0;
            m_last_reg  <= 1'b0;
        end else if (cmd.commit) begin
            m_city_reg  <= nnt_pkg::CITY_OUT_W'(best_reg);
            m_total_reg <= '0;
            m_last_reg  <= 1'b0;
        end else if (cmd.close_emit) begin
            m_city_reg  <= '0;
            m_total_reg <= close_total;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_city         = m_city_reg;
    assign m_total_length = m_total_reg;
    assign m_last_of_run  = m_last_reg;

    // Status
    always_comb begin
        status.out_free   = out_free;
        status.scan_last  = (NW'(j_reg) == (n_reg - NW'(1)));
        status.no_steps   = (rem_reg == '0);
        status.final_step = (rem_reg == NW'(1));
    end

endmodule

/* rtl/nearest_neighbour_tour_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_core - greedy nearest-neighbour tour builder
//
// Loads a distance matrix and emits a greedy tour starting and ending at
// city 0, with the summed length on the closing item.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per cycle while the core is idle; an entry
// with s_last_entry set is stored and then starts a tour, during which
// s_ready is low. The tour presents the opening city, then per step runs
// one row scan reading a single matrix entry per cycle from the distance
// memory's one read port, plus a compare and a commit state, then reads and
// adds the return leg. N+1 items follow (city 0, the visited cities, city 0
// again with m_last_of_run and the length, saturated at 2^29-1). The matrix
// memory is not cleared at reset; every entry a tour reads must have been
// written. cfg_data sets the city count (0 acts as 1, above MAX_CITIES acts
// as MAX_CITIES) and must be written only while the core is idle; the core
// itself does not enforce this.
module nearest_neighbour_tour_core #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnt_pkg::COUNT_W-1:0]     cfg_data,
    // matrix entries
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nnt_pkg::ROW_W-1:0]       s_row_index,
    input  logic [nnt_pkg::COL_W-1:0]       s_col_index,
    input  logic [nnt_pkg::DIST_IN_W-1:0]   s_distance,
    input  logic                            s_last_entry,
    // tour items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nnt_pkg::CITY_OUT_W-1:0]  m_city,
    output logic [nnt_pkg::TOTAL_W-1:0]     m_total_length,
    output logic                            m_last_of_run
);

    nnt_pkg::cmd_t    cmd;
    nnt_pkg::status_t status;

    // Register is always writable
    assign cfg_ready = 1'b1;

    nnt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_entry (s_last_entry),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    nnt_dpath #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_distance     (s_distance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_city         (m_city),
        .m_total_length (m_total_length),
        .m_last_of_run  (m_last_of_run),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

/* rtl/nnt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnt_checker - port-level checks for the nearest-neighbour tour core
//
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module nnt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_last_entry,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [nnt_pkg::CITY_OUT_W-1:0]  m_city,
    input logic [nnt_pkg::TOTAL_W-1:0]     m_total_length,
    input logic                            m_last_of_run
);

    // A stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_city)
                                && $stable(m_total_length) && $stable(m_last_of_run))
    else $error("stalled result item changed");

    // Length shows only on the closing item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_total_length == '0)
    else $error("length reported before closing item");

    // Closing item returns to city 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_run |-> m_city == '0)
    else $error("tour does not close at city 0");

    // Input is held off once a tour starts
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_entry |=> !s_ready)
    else $error("input taken during tour");

endmodule

bind nearest_neighbour_tour_core nnt_checker u_nnt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_entry   (s_last_entry),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_city         (m_city),
    .m_total_length (m_total_length),
    .m_last_of_run  (m_last_of_run)
);

/* dv/nearest_neighbour_tour_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_core_test - self-checking bench for the tour core
//
// Loads distance matrices into the core, sets the city count between tours
// and checks every tour item against a greedy nearest-neighbour predictor
// kept in the bench. Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_core_test;

    localparam int MAX_CITIES    = 32;
    localparam int DIST_WIDTH    = 24;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int ITEM_TARGET   = 360;

    // one pending item for the driver: a count write or a matrix entry
    typedef struct {
        bit                                 is_count;
        logic [nnt_pkg::COUNT_W-1:0]        count;
        logic [nnt_pkg::ROW_W-1:0]          row;
        logic [nnt_pkg::COL_W-1:0]          col;
        logic [nnt_pkg::DIST_IN_W-1:0]      dist_val;
        logic                               last;
    } load_op_t;

    // one expected tour item
    typedef struct {
        logic [nnt_pkg::CITY_OUT_W-1:0] city;
        logic [nnt_pkg::TOTAL_W-1:0]    total;
        logic                           last;
    } stop_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [nnt_pkg::COUNT_W-1:0]        cfg_data;
    logic                               s_valid;
    logic                               s_ready;
    logic [nnt_pkg::ROW_W-1:0]          s_row_index;
    logic [nnt_pkg::COL_W-1:0]          s_col_index;
    logic [nnt_pkg::DIST_IN_W-1:0]      s_distance;
    logic                               s_last_entry;
    logic                               m_valid;
    logic                               m_ready;
    logic [nnt_pkg::CITY_OUT_W-1:0]     m_city;
    logic [nnt_pkg::TOTAL_W-1:0]        m_total_length;
    logic                               m_last_of_run;

    load_op_t              entry_q [$];
    stop_t                 tour_stops_q [$];

    // predictor state
    logic [nnt_pkg::DIST_IN_W-1:0] dist_mem [MAX_CITIES][MAX_CITIES];
    logic [nnt_pkg::COUNT_W-1:0]   city_count_r = 6'd1;

    // stimulus bookkeeping: which matrix entries hold a written value
    bit                    filled [MAX_CITIES][MAX_CITIES];
    int                    item_cnt    = 0;

    int                    cycle_cnt   = 0;
    int                    quiet_cnt   = 0;
    int                    fault_cnt   = 0;
    logic                  entry_took  = 1'b0;
    logic                  count_took  = 1'b0;
    logic                  calm;

    nearest_neighbour_tour_core #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_WIDTH (DIST_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_distance     (s_distance),
        .s_last_entry   (s_last_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_city         (m_city),
        .m_total_length (m_total_length),
        .m_last_of_run  (m_last_of_run)
    );

    // no stalls on either side in this window
    assign calm = (cycle_cnt >= 600) && (cycle_cnt < 1600);

    // cities actually used for a register value: 0 acts as 1, saturate high
    function automatic int active_cities(input logic [nnt_pkg::COUNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_CITIES) return MAX_CITIES;
        return int'(v);
    endfunction

    // store an entry; on the marked entry walk the greedy tour
    task automatic store_and_walk(input logic [nnt_pkg::ROW_W-1:0] row,
                                  input logic [nnt_pkg::COL_W-1:0] col,
                                  input logic [nnt_pkg::DIST_IN_W-1:0] dist_val,
                                  input logic last);
        int                            n;
        int                            here;
        int                            best;
        int                            step;
        int                            j;
        bit                            found;
        bit                            seen [MAX_CITIES];
        logic [nnt_pkg::DIST_IN_W-1:0] best_d;
        longint unsigned               run_len;
        stop_t                         stop;

        dist_mem[row][col] = dist_val;
        if (!last) return;

        n = active_cities(city_count_r);
        foreach (seen[k]) seen[k] = 1'b0;
        seen[0] = 1'b1;
        here    = 0;
        run_len = 0;
        stop    = '{city: '0, total: '0, last: 1'b0};
        tour_stops_q.insert(tour_stops_q.size(), stop);

        for (step = 1; step < n; step++) begin
            found  = 1'b0;
            best   = 0;
            best_d = '0;
            // strictly smaller wins, so the lowest index keeps a tie
            for (j = 0; j < n; j++) begin
                if (!seen[j] && (!found || dist_mem[here][j] < best_d)) begin
                    found  = 1'b1;
                    best_d = dist_mem[here][j];
                    best   = j;
                end
            end
            if (found) begin
                run_len   += best_d;
                seen[best] = 1'b1;
                here       = best;
                stop       = '{city: best[nnt_pkg::CITY_OUT_W-1:0], total: '0,
                               last: 1'b0};
                tour_stops_q.insert(tour_stops_q.size(), stop);
            end
        end

        // return leg, length saturates at the field maximum
        run_len += dist_mem[here][0];
        stop.city  = '0;
        stop.total = (run_len > nnt_pkg::TOTAL_MAX) ? nnt_pkg::TOTAL_MAX
                                                     : run_len[nnt_pkg::TOTAL_W-1:0];
        stop.last  = 1'b1;
        tour_stops_q.insert(tour_stops_q.size(), stop);
    endtask

    function automatic logic [nnt_pkg::DIST_IN_W-1:0] pick_dist();
        logic [nnt_pkg::DIST_IN_W-1:0] val;
        int unsigned                   raw;
        raw = $urandom;
        case ($urandom_range(0, 9)) inside
            [0:3]:   val = raw[nnt_pkg::DIST_IN_W-1:0] & 24'd7; // small: plenty of ties
            4:       val = '1;
            5:       val = '0;
            default: val = raw[nnt_pkg::DIST_IN_W-1:0];
        endcase
        return val;
    endfunction

    task automatic queue_count(input int v);
        load_op_t op;
        op = '{is_count: 1'b1, count: v[nnt_pkg::COUNT_W-1:0], row: '0, col: '0,
               dist_val: '0, last: 1'b0};
        entry_q.insert(entry_q.size(), op);
    endtask

    task automatic queue_entry(input int row, input int col,
                               input logic [nnt_pkg::DIST_IN_W-1:0] dist_val,
                               input logic last);
        load_op_t op;
        op = '{is_count: 1'b0, count: '0, row: row[nnt_pkg::ROW_W-1:0],
               col: col[nnt_pkg::COL_W-1:0], dist_val: dist_val, last: last};
        filled[row][col] = 1'b1;
        item_cnt++;
        entry_q.insert(entry_q.size(), op);
    endtask

    // count write, any entries the tour still lacks, some rewrites, then the
    // marked entry that starts the tour
    task automatic queue_tour(input int v, input int extras);
        int n;
        int k;
        n = active_cities(v[nnt_pkg::COUNT_W-1:0]);
        queue_count(v);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!filled[r][c])
                    queue_entry(r, c, pick_dist(), 1'b0);
        for (k = 0; k < extras; k++)
            queue_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                        pick_dist(), 1'b0);
        queue_entry($urandom_range(0, MAX_CITIES - 1), $urandom_range(0, MAX_CITIES - 1),
                    pick_dist(), 1'b1);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // stimulus, reset and end of run
    initial begin
        int sel;
        int v;
        int extras;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_row_index  = '0;
        s_col_index  = '0;
        s_distance   = '0;
        s_last_entry = 1'b0;
        m_ready      = 1'b0;

        // single city at the largest distance
        queue_count(1);
        queue_entry(0, 0, '1, 1'b1);
        // count of zero acts as one city
        queue_count(0);
        queue_entry(0, 0, '0, 1'b1);
        // three cities, every outgoing distance equal: lowest index wins
        queue_count(3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                queue_entry(r, c, (r == c) ? 24'hFFFFFF : 24'd7, (r == 2 && c == 2));
        // two cities, long way home
        queue_count(2);
        queue_entry(1, 0, '1, 1'b1);
        // four cities: a tied minimum behind a larger first distance
        queue_count(4);
        queue_entry(0, 1, 24'd5, 1'b0);
        queue_entry(0, 2, 24'd3, 1'b0);
        queue_entry(0, 3, 24'd3, 1'b0);
        queue_tour(4, 0);

        // mostly small tours with random content
        while (item_cnt < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)      v = $urandom_range(2, 6);
            else if (sel < 87) v = $urandom_range(7, 12);
            else if (sel < 93) v = 0;
            else               v = 1;
            extras = $urandom_range(0, 8);
            queue_tour(v, extras);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (entry_q.size() != 0 || s_valid || cfg_valid || tour_stops_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tour_stops_q.size() != 0) begin
            $display("%0t: %0d tour items never arrived", $time, tour_stops_q.size());
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("[nearest_neighbour_tour_core] OK");
        else
            $display("[nearest_neighbour_tour_core] ERROR");
        $finish;
    end

    // driver: next item goes out on the falling edge once the last one is taken
    always @(negedge aclk) begin
        load_op_t op;
        bit       s_hold;
        bit       c_hold;
        bit       s_next;
        bit       c_next;

        s_hold = s_valid && !entry_took;
        c_hold = cfg_valid && !count_took;
        s_next = s_hold;
        c_next = c_hold;
        if (aresetn && !s_hold && !c_hold && entry_q.size() != 0
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            op = entry_q[0];
            if (op.is_count) begin
                // count only changes with the core idle and the tour drained
                if (tour_stops_q.size() == 0 && quiet_cnt >= SETTLE_CYCLES) begin
                    cfg_data <= op.count;
                    c_next = 1'b1;
                    void'(entry_q.pop_front());
                end
            end else begin
                s_row_index  <= op.row;
                s_col_index  <= op.col;
                s_distance   <= op.dist_val;
                s_last_entry <= op.last;
                s_next = 1'b1;
                void'(entry_q.pop_front());
            end
        end
        s_valid   <= s_next;
        cfg_valid <= c_next;
    end

    // result side back-pressure
    always @(negedge aclk)
        m_ready <= aresetn && (calm || $urandom_range(0, 99) >= IDLE_PCT);

    // monitor and predictor, all on the rising edge
    always @(posedge aclk) begin
        stop_t want;

        cycle_cnt  <= cycle_cnt + 1;
        entry_took <= s_valid && s_ready;
        count_took <= cfg_valid && cfg_ready;
        if (s_valid && s_ready)
            quiet_cnt <= 0;
        else if (quiet_cnt < SETTLE_CYCLES)
            quiet_cnt <= quiet_cnt + 1;

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[nearest_neighbour_tour_core] ERROR");
            $finish;
        end

        // tour item out
        if (aresetn && m_valid && m_ready) begin
            if (tour_stops_q.size() == 0) begin
                $display("%0t: unexpected tour item city %0d total %0d last %0b",
                         $time, m_city, m_total_length, m_last_of_run);
                fault_cnt++;
            end else begin
                want = tour_stops_q.pop_front();
                if (m_city !== want.city) begin
                    $display("%0t: city expected %0d got %0d", $time, want.city, m_city);
                    fault_cnt++;
                end
                if (m_total_length !== want.total) begin
                    $display("%0t: total_length expected %0d got %0d",
                             $time, want.total, m_total_length);
                    fault_cnt++;
                end
                if (m_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b got %0b",
                             $time, want.last, m_last_of_run);
                    fault_cnt++;
                end
            end
        end

        // register write and matrix item in
        if (aresetn && cfg_valid && cfg_ready)
            city_count_r = cfg_data;
        if (aresetn && s_valid && s_ready)
            store_and_walk(s_row_index, s_col_index, s_distance, s_last_entry);
    end

endmodule

/* sim.f */
rtl/nnt_pkg.sv
rtl/nnt_ctrl.sv
rtl/nnt_dpath.sv
rtl/nearest_neighbour_tour_core.sv
rtl/nnt_checker.sv
dv/nearest_neighbour_tour_core_test.sv
